// File: hw/rtl/mwp_pkg.sv
// ----------------------------------------------------------------------------
// Memory write packetizer package
// Character codes, register indexes, back end states and small helpers.
// ----------------------------------------------------------------------------
package mwp_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegBaseAddress   = 2'd0;
  localparam logic [1:0] RegSegmentLength = 2'd1;
  localparam logic [1:0] RegPacketSize    = 2'd2;

  localparam logic [12:0] PacketSizeReset = 13'd256;

  // Packet body characters.
  localparam logic [7:0] ChX      = 8'h58;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChEscape = 8'h7d;
  localparam logic [7:0] EscXor   = 8'h20;

  typedef enum logic [6:0] {
    StHead  = 7'b0000001,
    StAddr  = 7'b0000010,
    StComma = 7'b0000100,
    StLen   = 7'b0001000,
    StColon = 7'b0010000,
    StData  = 7'b0100000,
    StEsc2  = 7'b1000000
  } back_state_e;

  // Index of the most significant non-zero nibble, zero for a zero value.
  function automatic logic [2:0] msd_nibble(input logic [31:0] value);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (value[i*4 +: 4] != 4'd0) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Lowercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == ChDollar) || (b == ChHash) || (b == ChEscape);
  endfunction

endpackage

// File: hw/rtl/mwp_front.sv
// ----------------------------------------------------------------------------
// Memory write packetizer front end
// Holds the configuration, segment and packet offsets, and turns each byte
// accepted at non-zero segment length into a queue entry with header values.
// ----------------------------------------------------------------------------
module mwp_front #(
  parameter int MaxPayload = 4096,
  localparam int LenW      = $clog2(MaxPayload + 1),
  localparam int EntryW    = 42 + LenW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  output logic              push_o,
  output logic [EntryW-1:0] entry_o,
  input  logic              full_i
);

  logic [31:0]     base_q, seg_len_q;
  logic [12:0]     pkt_size_q;
  logic [31:0]     seg_off_q, seg_off_d;
  logic [LenW-1:0] pkt_off_q, pkt_off_d;
  logic [LenW-1:0] pkt_len_q, pkt_len_d;

  logic            accept, open_pkt, pkt_end;
  logic [LenW-1:0] psize, plen, poff_inc;
  logic [31:0]     so, left, so_inc, addr;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (seg_len_q != 32'd0);

  always_comb begin
    open_pkt = (pkt_off_q == '0);
    if (pkt_size_q == 13'd0) begin
      psize = LenW'(1);
    end else if (32'(pkt_size_q) > 32'(MaxPayload)) begin
      psize = LenW'(MaxPayload);
    end else begin
      psize = LenW'(pkt_size_q);
    end
    so   = (open_pkt && (seg_off_q >= seg_len_q)) ? 32'd0 : seg_off_q;
    left = seg_len_q - so;
    addr = base_q + so;
    if (!open_pkt) begin
      plen = pkt_len_q;
    end else if (left < 32'(psize)) begin
      plen = LenW'(left);
    end else begin
      plen = psize;
    end
    poff_inc = pkt_off_q + LenW'(1);
    so_inc   = so + 32'd1;
    pkt_end  = (poff_inc >= plen);

    pkt_len_d = plen;
    pkt_off_d = pkt_end ? '0 : poff_inc;
    seg_off_d = (pkt_end && (so_inc >= seg_len_q)) ? 32'd0 : so_inc;
  end

  assign entry_o = {data_byte_i, open_pkt, pkt_end, addr, plen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= 32'd0;
      seg_len_q  <= 32'd0;
      pkt_size_q <= mwp_pkg::PacketSizeReset;
      seg_off_q  <= 32'd0;
      pkt_off_q  <= '0;
      pkt_len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mwp_pkg::RegBaseAddress:   base_q     <= cfg_wdata_i;
          mwp_pkg::RegSegmentLength: seg_len_q  <= cfg_wdata_i;
          mwp_pkg::RegPacketSize:    pkt_size_q <= cfg_wdata_i[12:0];
          default: ;
        endcase
      end
      if (push_o) begin
        seg_off_q <= seg_off_d;
        pkt_off_q <= pkt_off_d;
        pkt_len_q <= pkt_len_d;
      end
    end
  end

endmodule

// File: hw/rtl/mwp_queue.sv
// ----------------------------------------------------------------------------
// Memory write packetizer queue
// Two-entry register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mwp_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/mwp_back.sv
// ----------------------------------------------------------------------------
// Memory write packetizer back end
// Sequences packet header text and escaped payload bytes into an output
// register, one byte per cycle unless held by back-pressure or an empty queue.
// ----------------------------------------------------------------------------
module mwp_back #(
  parameter int MaxPayload = 4096,
  localparam int LenW      = $clog2(MaxPayload + 1),
  localparam int EntryW    = 42 + LenW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [EntryW-1:0] q_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              packet_end_o,
  output logic              run_last_o
);

  mwp_pkg::back_state_e state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        pe_q, pe_d, rl_q, rl_d;

  logic [7:0]      e_data;
  logic            e_open, e_end;
  logic [31:0]     e_addr, e_len, hex_val;
  logic [LenW-1:0] e_len_n;
  logic            adv, esc;

  assign {e_data, e_open, e_end, e_addr, e_len_n} = q_entry_i;
  assign e_len   = 32'(e_len_n);
  assign esc     = mwp_pkg::needs_escape(e_data);
  assign adv     = !ov_q || out_ready_i;
  assign hex_val = (state_q == mwp_pkg::StLen) ? e_len : e_addr;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_ready_i;
    ob_d    = ob_q;
    pe_d    = pe_q;
    rl_d    = rl_q;
    pop_o   = 1'b0;
    if (adv && q_valid_i) begin
      ov_d = 1'b1;
      pe_d = 1'b0;
      rl_d = 1'b0;
      unique case (state_q) inside
        mwp_pkg::StHead, mwp_pkg::StData: begin
          if ((state_q == mwp_pkg::StHead) && e_open) begin
            ob_d    = mwp_pkg::ChX;
            idx_d   = mwp_pkg::msd_nibble(e_addr);
            state_d = mwp_pkg::StAddr;
          end else if (esc) begin
            ob_d    = mwp_pkg::ChEscape;
            state_d = mwp_pkg::StEsc2;
          end else begin
            ob_d    = e_data;
            pe_d    = e_end;
            rl_d    = 1'b1;
            pop_o   = 1'b1;
            state_d = mwp_pkg::StHead;
          end
        end
        mwp_pkg::StAddr, mwp_pkg::StLen: begin
          ob_d  = mwp_pkg::hex_char(hex_val[idx_q*4 +: 4]);
          idx_d = idx_q - 3'd1;
          if (idx_q == 3'd0) begin
            state_d = (state_q == mwp_pkg::StAddr) ? mwp_pkg::StComma
                                                   : mwp_pkg::StColon;
          end
        end
        mwp_pkg::StComma: begin
          ob_d    = mwp_pkg::ChComma;
          idx_d   = mwp_pkg::msd_nibble(e_len);
          state_d = mwp_pkg::StLen;
        end
        mwp_pkg::StColon: begin
          ob_d    = mwp_pkg::ChColon;
          state_d = mwp_pkg::StData;
        end
        mwp_pkg::StEsc2: begin
          ob_d    = e_data ^ mwp_pkg::EscXor;
          pe_d    = e_end;
          rl_d    = 1'b1;
          pop_o   = 1'b1;
          state_d = mwp_pkg::StHead;
        end
        default: state_d = mwp_pkg::StHead;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwp_pkg::StHead;
      idx_q   <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    pe_q <= pe_d;
    rl_q <= rl_d;
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign packet_end_o = pe_q;
  assign run_last_o   = rl_q;

endmodule

// File: hw/rtl/memory_write_packetizer.sv
// The first output byte of a transaction is loaded into the back end output register from
// the queue entry that the front end wrote when it accepted the byte.
// Throughput: one output byte per cycle, set by the back end sequencer, unless it is stalled;
// a payload byte goes out as one byte, or two when escaped, and each packet adds a header.
// The front end takes a byte every cycle while the two-entry queue has room.
// Reset clears the offsets, queue and sequencer and loads the register reset values.
// ----------------------------------------------------------------------------
// Memory write packetizer
// Turns segment bytes into binary memory-write packet bodies with hex headers.
// ----------------------------------------------------------------------------
module memory_write_packetizer #(
  parameter int MaxPayload = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic        run_last_o
);

  localparam int LenW   = $clog2(MaxPayload + 1);
  localparam int EntryW = 42 + LenW;

  logic              push, full, pop, q_valid;
  logic [EntryW-1:0] wentry, rentry;

  mwp_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (wentry),
    .full_i      (full)
  );

  mwp_queue #(.Width(EntryW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (rentry)
  );

  mwp_back #(.MaxPayload(MaxPayload)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (rentry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .run_last_o   (run_last_o)
  );

endmodule
